@@ rtl/dsfa_pkg.sv @@
// Shared constants and helpers for the particle-sensor frame averager.
// No dependencies; used by dust_sensor_frame_averager.
`default_nettype none

package dsfa_pkg;

  localparam int FRAME_BYTES_DEF = 32;

  localparam logic [7:0] PRE_FIRST  = 8'h42;  // 'B'
  localparam logic [7:0] PRE_SECOND = 8'h4D;  // 'M'

  // frame byte positions of the concentration words (high byte first)
  localparam int PM1_0_HI_POS = 10;
  localparam int PM1_0_LO_POS = 11;
  localparam int PM2_5_HI_POS = 12;
  localparam int PM2_5_LO_POS = 13;
  localparam int PM10_HI_POS  = 14;
  localparam int PM10_LO_POS  = 15;

  localparam logic [15:0] FINE_LIMIT_RST   = 16'd25;
  localparam logic [15:0] COARSE_LIMIT_RST = 16'd50;

  localparam int FRAMES_PER_MEAN = 3;
  localparam int TOTAL_W         = 18;

  typedef enum logic {
    REG_FINE_LIMIT   = 1'b0,
    REG_COARSE_LIMIT = 1'b1
  } cfg_reg_t;

  // floor(x / 3), kept to 16 bits, for x < 3 * 2^16: multiply by ceil(2^19 / 3) and shift
  function automatic logic [15:0] div3(input logic [TOTAL_W-1:0] x);
    logic [36:0] prod;
    prod = {19'd0, x} * 37'd174763;
    return prod[34:19];
  endfunction

endpackage

`default_nettype wire

@@ rtl/dust_sensor_frame_averager.sv @@
// Particle-sensor frame parser with three-frame PM averaging.
// Depends on dsfa_pkg.
`default_nettype none

// Takes one received serial byte per item and accepts a byte every cycle while
// the result register is free or being drained. It syncs on the 'B','M'
// preamble, gathers a FRAME_BYTES long frame and, on the frame's last byte,
// returns one item in the next cycle: the checksum flag, the PM1.0/PM2.5/PM10
// words, and on every third good frame the truncated PM2.5/PM10 means with a
// poor-air flag. Bytes that do not end a frame give no item. Limits are
// written through the cfg port while the block is idle; the block itself does not enforce this.
module dust_sensor_frame_averager #(
  parameter int FRAME_BYTES = dsfa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [0] checksum_ok, [16:1] pm1_0, [32:17] pm2_5, [48:33] pm10,
  // [49] average_ready, [65:50] mean_pm2_5, [81:66] mean_pm10, [82] poor_air
  output      logic [87:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int SUM_W = $clog2((FRAME_BYTES - 2) * 255 + 1);
  localparam int TW    = dsfa_pkg::TOTAL_W;

  localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_WAITM = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHKHI = POS_W'(FRAME_BYTES - 2);

  logic [15:0]      fine_limit_r, coarse_limit_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]       check_high_r, check_high_nxt;
  logic [15:0]      f10_r, f10_nxt, f25_r, f25_nxt, f100_r, f100_nxt;
  logic [1:0]       good_r, good_nxt;
  logic [TW-1:0]    tot25_r, tot25_nxt, tot10_r, tot10_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [87:0]      out_data_r, out_data_nxt;

  logic             in_acc;
  logic [7:0]       b;
  logic [15:0]      check;
  logic             ok, ready, poor;
  logic [TW-1:0]    add25, add10;
  logic [15:0]      m25, m10;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign check = {check_high_r, b};
  assign ok    = ({{(16 - SUM_W){1'b0}}, sum_r} == check);
  assign add25 = tot25_r + {{(TW - 16){1'b0}}, f25_r};
  assign add10 = tot10_r + {{(TW - 16){1'b0}}, f100_r};
  assign ready = ok && (good_r == 2'(dsfa_pkg::FRAMES_PER_MEAN - 1));
  assign m25   = dsfa_pkg::div3(add25);
  assign m10   = dsfa_pkg::div3(add10);
  assign poor  = (m25 > fine_limit_r) && (m10 > coarse_limit_r);

  always_comb begin
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    check_high_nxt = check_high_r;
    f10_nxt        = f10_r;
    f25_nxt        = f25_r;
    f100_nxt       = f100_r;
    good_nxt       = good_r;
    tot25_nxt      = tot25_r;
    tot10_nxt      = tot10_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    if (in_acc) begin
      if (pos_r == POS_HUNT) begin
        if (b == dsfa_pkg::PRE_FIRST) pos_nxt = POS_WAITM;
      end else if (pos_r == POS_WAITM) begin
        if (b == dsfa_pkg::PRE_SECOND) begin
          sum_nxt = SUM_W'(dsfa_pkg::PRE_FIRST) + SUM_W'(dsfa_pkg::PRE_SECOND);
          pos_nxt = POS_BODY;
        end else if (b == dsfa_pkg::PRE_FIRST) begin
          pos_nxt = POS_WAITM;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end else if (pos_r < POS_CHKHI) begin
        sum_nxt = sum_r + {{(SUM_W - 8){1'b0}}, b};
        if (pos_r == POS_W'(dsfa_pkg::PM1_0_HI_POS)) f10_nxt = {b, 8'd0};
        if (pos_r == POS_W'(dsfa_pkg::PM1_0_LO_POS)) f10_nxt = {f10_r[15:8], b};
        if (pos_r == POS_W'(dsfa_pkg::PM2_5_HI_POS)) f25_nxt = {b, 8'd0};
        if (pos_r == POS_W'(dsfa_pkg::PM2_5_LO_POS)) f25_nxt = {f25_r[15:8], b};
        if (pos_r == POS_W'(dsfa_pkg::PM10_HI_POS))  f100_nxt = {b, 8'd0};
        if (pos_r == POS_W'(dsfa_pkg::PM10_LO_POS))  f100_nxt = {f100_r[15:8], b};
        pos_nxt = pos_r + POS_W'(1);
      end else if (pos_r == POS_CHKHI) begin
        check_high_nxt = b;
        pos_nxt        = pos_r + POS_W'(1);
      end else begin
        // last frame byte
        pos_nxt = POS_HUNT;
        if (ok) begin
          if (ready) begin
            good_nxt  = 2'd0;
            tot25_nxt = '0;
            tot10_nxt = '0;
          end else begin
            good_nxt  = good_r + 2'd1;
            tot25_nxt = add25;
            tot10_nxt = add10;
          end
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = {5'd0, ready && poor,
                         ready ? m10 : 16'd0, ready ? m25 : 16'd0, ready,
                         f100_r, f25_r, f10_r, ok};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_limit_r   <= dsfa_pkg::FINE_LIMIT_RST;
      coarse_limit_r <= dsfa_pkg::COARSE_LIMIT_RST;
      pos_r          <= POS_HUNT;
      sum_r          <= '0;
      check_high_r   <= '0;
      f10_r          <= '0;
      f25_r          <= '0;
      f100_r         <= '0;
      good_r         <= '0;
      tot25_r        <= '0;
      tot10_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dsfa_pkg::cfg_reg_t'(cfg_addr))
          dsfa_pkg::REG_FINE_LIMIT:   fine_limit_r   <= cfg_wdata;
          dsfa_pkg::REG_COARSE_LIMIT: coarse_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r        <= pos_nxt;
      sum_r        <= sum_nxt;
      check_high_r <= check_high_nxt;
      f10_r        <= f10_nxt;
      f25_r        <= f25_nxt;
      f100_r       <= f100_nxt;
      good_r       <= good_nxt;
      tot25_r      <= tot25_nxt;
      tot10_r      <= tot10_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_frame_end_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (pos_r == POS_W'(FRAME_BYTES - 1)) |=> out_valid_r)
    else $error("frame end gave no item");

  a_avg_needs_good_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r[49] || out_data_r[82]) |-> out_data_r[0] && out_data_r[49])
    else $error("average flags without good checksum");

  a_good_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ready && (pos_r == POS_W'(FRAME_BYTES - 1))
    |=> (good_r == 2'd0) && (tot25_r == '0) && (tot10_r == '0))
    else $error("accumulators not cleared after mean");
`endif

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for dust_sensor_frame_averager: streams sensor bytes,
// predicts every frame result and compares it field by field.
// Depends on dsfa_pkg and the dust_sensor_frame_averager RTL.
module testbench;

  localparam int FB             = dsfa_pkg::FRAME_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 240;
  localparam int RANDOM_BYTES   = 640;

  typedef struct {
    logic        checksum_ok;
    logic [15:0] pm1_0;
    logic [15:0] pm2_5;
    logic [15:0] pm10;
    logic        average_ready;
    logic [15:0] mean_pm2_5;
    logic [15:0] mean_pm10;
    logic        poor_air;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  wire         in_tready;
  wire         out_tvalid;
  wire  [87:0] out_tdata;

  // predicted block state
  logic [15:0] fine_lim = dsfa_pkg::FINE_LIMIT_RST;
  logic [15:0] coarse_lim = dsfa_pkg::COARSE_LIMIT_RST;
  logic [5:0]  frame_pos = '0;
  logic [15:0] byte_sum = '0;
  logic [7:0]  check_hi = '0;
  logic [15:0] word_pm1_0 = '0;
  logic [15:0] word_pm2_5 = '0;
  logic [15:0] word_pm10 = '0;
  logic [1:0]  good_count = '0;
  logic [dsfa_pkg::TOTAL_W-1:0] sum_pm2_5 = '0;
  logic [dsfa_pkg::TOTAL_W-1:0] sum_pm10 = '0;

  frame_result_t expected_frames[$];
  frame_result_t want;

  int errors = 0;
  int frames_seen = 0;
  int averages_seen = 0;
  int poor_seen = 0;
  int send_gap_max = 5;
  int recv_gap_max = 5;
  int hold_request = 0;
  int quiet_cycles = 0;

  dust_sensor_frame_averager uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    logic [15:0] check;
    if (frame_pos == 0) begin
      if (b == dsfa_pkg::PRE_FIRST) frame_pos = 6'd1;
    end else if (frame_pos == 1) begin
      if (b == dsfa_pkg::PRE_SECOND) begin
        byte_sum = 16'(dsfa_pkg::PRE_FIRST) + 16'(dsfa_pkg::PRE_SECOND);
        frame_pos = 6'd2;
      end else if (b != dsfa_pkg::PRE_FIRST) begin
        frame_pos = 6'd0;
      end
    end else if (frame_pos < FB - 2) begin
      byte_sum = byte_sum + 16'(b);
      case (int'(frame_pos))
        dsfa_pkg::PM1_0_HI_POS: word_pm1_0 = {b, 8'h00};
        dsfa_pkg::PM1_0_LO_POS: word_pm1_0[7:0] = b;
        dsfa_pkg::PM2_5_HI_POS: word_pm2_5 = {b, 8'h00};
        dsfa_pkg::PM2_5_LO_POS: word_pm2_5[7:0] = b;
        dsfa_pkg::PM10_HI_POS:  word_pm10 = {b, 8'h00};
        dsfa_pkg::PM10_LO_POS:  word_pm10[7:0] = b;
        default: ;
      endcase
      frame_pos = frame_pos + 6'd1;
    end else if (frame_pos == FB - 2) begin
      check_hi = b;
      frame_pos = frame_pos + 6'd1;
    end else begin
      frame_pos = 6'd0;
      check = {check_hi, b};
      r.checksum_ok = (byte_sum == check);
      r.average_ready = 1'b0;
      r.mean_pm2_5 = '0;
      r.mean_pm10 = '0;
      r.poor_air = 1'b0;
      if (r.checksum_ok) begin
        sum_pm2_5 = sum_pm2_5 + dsfa_pkg::TOTAL_W'(word_pm2_5);
        sum_pm10 = sum_pm10 + dsfa_pkg::TOTAL_W'(word_pm10);
        good_count = good_count + 2'd1;
        if (good_count >= dsfa_pkg::FRAMES_PER_MEAN) begin
          r.average_ready = 1'b1;
          r.mean_pm2_5 = 16'(sum_pm2_5 / dsfa_pkg::FRAMES_PER_MEAN);
          r.mean_pm10 = 16'(sum_pm10 / dsfa_pkg::FRAMES_PER_MEAN);
          r.poor_air = (r.mean_pm2_5 > fine_lim) && (r.mean_pm10 > coarse_lim);
          good_count = '0;
          sum_pm2_5 = '0;
          sum_pm10 = '0;
        end
      end
      r.pm1_0 = word_pm1_0;
      r.pm2_5 = word_pm2_5;
      r.pm10 = word_pm10;
      expected_frames.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    predict_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] p1, input logic [15:0] p25,
                            input logic [15:0] p10, input bit bad_sum, input bit odd_len);
    logic [7:0] f[FB];
    logic [15:0] s;
    f[0] = dsfa_pkg::PRE_FIRST;
    f[1] = dsfa_pkg::PRE_SECOND;
    for (int i = 4; i < FB - 2; i++) f[i] = 8'($urandom);
    f[2] = odd_len ? 8'($urandom) : 8'h00;
    f[3] = odd_len ? 8'($urandom) : 8'(FB - 4);
    f[dsfa_pkg::PM1_0_HI_POS] = p1[15:8];
    f[dsfa_pkg::PM1_0_LO_POS] = p1[7:0];
    f[dsfa_pkg::PM2_5_HI_POS] = p25[15:8];
    f[dsfa_pkg::PM2_5_LO_POS] = p25[7:0];
    f[dsfa_pkg::PM10_HI_POS]  = p10[15:8];
    f[dsfa_pkg::PM10_LO_POS]  = p10[7:0];
    s = '0;
    for (int i = 0; i < FB - 2; i++) s = s + 16'(f[i]);
    if (bad_sum) s = s ^ 16'($urandom_range(1, 65535));
    f[FB-2] = s[15:8];
    f[FB-1] = s[7:0];
    for (int i = 0; i < FB; i++) send_byte(f[i]);
  endtask

  // drop valid and let every pending result drain
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input dsfa_pkg::cfg_reg_t r, input logic [15:0] v);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (r == dsfa_pkg::REG_FINE_LIMIT) fine_lim = v;
    else coarse_lim = v;
  endtask

  function automatic logic [15:0] random_pm();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 120));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frames.size() == 0) begin
        $error("result item with none expected: %h", out_tdata);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        check_field("checksum_ok", 16'(want.checksum_ok), 16'(out_tdata[0]));
        check_field("pm1_0", want.pm1_0, out_tdata[16:1]);
        check_field("pm2_5", want.pm2_5, out_tdata[32:17]);
        check_field("pm10", want.pm10, out_tdata[48:33]);
        check_field("average_ready", 16'(want.average_ready), 16'(out_tdata[49]));
        check_field("mean_pm2_5", want.mean_pm2_5, out_tdata[65:50]);
        check_field("mean_pm10", want.mean_pm10, out_tdata[81:66]);
        check_field("poor_air", 16'(want.poor_air), 16'(out_tdata[82]));
        frames_seen++;
        if (want.average_ready) averages_seen++;
        if (want.poor_air) poor_seen++;
      end
    end
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    int gap;
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        repeat (n) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      gap = $urandom_range(0, recv_gap_max);
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_preamble_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dsfa_pkg::PRE_SECOND);
    send_byte(dsfa_pkg::PRE_FIRST);
    send_byte(8'h11);
    send_byte(dsfa_pkg::PRE_FIRST);
    send_byte(dsfa_pkg::PRE_FIRST);
    send_frame(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
  endtask

  task automatic test_frame_fields();
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_frame(16'h1234, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_frame(16'hA5A5, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    repeat (3) send_frame(16'd5, 16'd10, 16'd40, 1'b0, 1'b0);
    repeat (3) send_frame(16'd7, 16'd90, 16'd20, 1'b0, 1'b0);
    repeat (3) send_frame(16'd7, 16'd26, 16'd51, 1'b0, 1'b0);
  endtask

  task automatic test_limit_extremes();
    write_limit(dsfa_pkg::REG_FINE_LIMIT, 16'h0000);
    write_limit(dsfa_pkg::REG_COARSE_LIMIT, 16'h0000);
    repeat (3) send_frame(16'd1, 16'd1, 16'd1, 1'b0, 1'b0);
    repeat (3) send_frame(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    write_limit(dsfa_pkg::REG_FINE_LIMIT, 16'hFFFF);
    write_limit(dsfa_pkg::REG_COARSE_LIMIT, 16'hFFFF);
    repeat (3) send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    write_limit(dsfa_pkg::REG_FINE_LIMIT, dsfa_pkg::FINE_LIMIT_RST);
    write_limit(dsfa_pkg::REG_COARSE_LIMIT, dsfa_pkg::COARSE_LIMIT_RST);
  endtask

  task automatic test_backpressure();
    send_gap_max = 0;
    hold_request = HOLD_CYCLES;
    repeat (6) send_frame(random_pm(), random_pm(), random_pm(), 1'b0, 1'b0);
    send_gap_max = 5;
  endtask

  task automatic test_random_traffic();
    int frame_bytes;
    int n;
    for (int phase = 0; phase < 4; phase++) begin
      write_limit(dsfa_pkg::REG_FINE_LIMIT,
                  (phase == 3) ? 16'($urandom) : 16'($urandom_range(0, 120)));
      write_limit(dsfa_pkg::REG_COARSE_LIMIT,
                  (phase == 3) ? 16'($urandom) : 16'($urandom_range(0, 150)));
      // one phase runs with no idle cycles on either side
      send_gap_max = (phase == 2) ? 0 : 5;
      recv_gap_max = (phase == 2) ? 0 : 5;
      frame_bytes = 0;
      while (frame_bytes < RANDOM_BYTES / 4) begin
        case ($urandom_range(0, 9))
          0: begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom));
          end
          1: begin
            send_byte(dsfa_pkg::PRE_FIRST);
            send_byte(8'($urandom));
          end
          2: begin
            send_frame(random_pm(), random_pm(), random_pm(), 1'b1,
                       1'($urandom_range(0, 1)));
            frame_bytes += FB;
          end
          3: begin
            // truncated frame, the next bytes complete it
            send_byte(dsfa_pkg::PRE_FIRST);
            send_byte(dsfa_pkg::PRE_SECOND);
            n = $urandom_range(0, 20);
            repeat (n) send_byte(8'($urandom));
            frame_bytes += n + 2;
          end
          default: begin
            send_frame(random_pm(), random_pm(), random_pm(), 1'b0,
                       $urandom_range(0, 7) == 0);
            frame_bytes += FB;
          end
        endcase
      end
    end
    send_gap_max = 5;
    recv_gap_max = 5;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_preamble_hunt();
    test_frame_fields();
    test_limit_extremes();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (5) @(posedge clk);
    $display("Checked %0d frame results, %0d averages (%0d poor air) over preamble hunting,",
             frames_seen, averages_seen, poor_seen);
    $display("bad checksums, truncated frames, limit extremes and output backpressure.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
